>>> sv/mqf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqf_pkg: shared types and constants of the MQTT packet framer
// Holds the phase, kind and error codes, field widths and the result record
// passed from the framing core to the output register.
// ----------------------------------------------------------------------------
package mqf_pkg;

    localparam int MAX_LENGTH_BYTES = 5;
    localparam int DIGIT_BITS       = 7;
    localparam int IDX_W            = 3;
    localparam int SHIFT_W          = 6;
    localparam int LEN_W            = 32;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        K_HEADER  = 2'd0,
        K_LENGTH  = 2'd1,
        K_PAYLOAD = 2'd2,
        K_ERROR   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        E_ZERO_HEADER = 2'd0,
        E_TOO_LONG    = 2'd1,
        E_MISSING     = 2'd2
    } err_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        byte_out;
        logic [7:0]        header_value;
        logic [LEN_W-1:0]  remaining_length;
        logic              packet_end;
        err_t              error_code;
    } result_t;

endpackage

>>> sv/mqtt_packet_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqtt_packet_framer: MQTT fixed header and remaining length framer
// Classifies each byte of a link stream as header, length, payload or error
// and marks the last byte of every packet.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | tdata                          | tuser    | tlast
//  ---------+-----------+--------------------------------+----------+-----------
//  s_*      | in        | data_byte                      | no_data  | -
//  m_*      | out       | byte_out, header_value,        | kind     | packet_end
//           |           | remaining_length, error_code   |          |
//
// Every input byte produces exactly one output transfer. Throughput is one
// byte per clock unless the output stalls; a byte passes the input register,
// then the result register behind the framing logic. The state update of the
// framing core sets this rate. Reset clears the framing state and both valid
// flags. A stall on the output holds the result register and, once the input
// register is also full, deasserts s_tready; no transfer is lost.
//
module mqtt_packet_framer
    import mqf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] no_data
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [7:0] byte_out, [15:8] header_value,
                                   // [47:16] remaining_length, [49:48] error_code,
                                   // [55:50] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // packet_end
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_flag_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    core_result;
    logic       advance;

    // A byte moves from the input register into the result register whenever
    // the result register is empty or its contents are being taken.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    mqf_frame_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .no_data   (in_flag_reg),
        .result    (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_flag_reg <= s_tuser;
        end
        if (advance)
        begin
            out_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.packet_end;
    assign m_tdata  = {6'd0, out_reg.error_code, out_reg.remaining_length,
                       out_reg.header_value, out_reg.byte_out};

endmodule

>>> sv/mqf_frame_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqf_frame_core: framing state and per-byte classification
// Classifies one registered input byte per step and updates the packet state.
// ----------------------------------------------------------------------------
module mqf_frame_core
    import mqf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       no_data,
    output result_t    result
);

    phase_t             phase_reg,       phase_next;
    logic [IDX_W-1:0]   digit_idx_reg,   digit_idx_next;
    logic [LEN_W-1:0]   acc_reg,         acc_next;
    logic [LEN_W-1:0]   bytes_left_reg,  bytes_left_next;
    logic [7:0]         header_reg,      header_next;

    logic [SHIFT_W-1:0] shift;
    logic [LEN_W-1:0]   group;
    logic [LEN_W-1:0]   acc_or;
    logic [LEN_W-1:0]   left_dec;

    // Each length byte contributes seven bits at position 7 * index.
    assign shift    = SHIFT_W'(digit_idx_reg) * SHIFT_W'(DIGIT_BITS);
    assign group    = LEN_W'({{(LEN_W-DIGIT_BITS){1'b0}}, data_byte[DIGIT_BITS-1:0]} << shift);
    assign acc_or   = acc_reg | group;
    assign left_dec = bytes_left_reg - LEN_W'(1);

    // Next state.
    always_comb
    begin
        phase_next      = phase_reg;
        digit_idx_next  = digit_idx_reg;
        acc_next        = acc_reg;
        bytes_left_next = bytes_left_reg;
        header_next     = header_reg;
        if (no_data)
        begin
            phase_next      = PH_HEADER;
            digit_idx_next  = '0;
            acc_next        = '0;
            bytes_left_next = '0;
        end
        else
        begin
            case (phase_reg)
                PH_LENGTH:
                begin
                    if (digit_idx_reg >= IDX_W'(MAX_LENGTH_BYTES))
                    begin
                        phase_next      = PH_HEADER;
                        digit_idx_next  = '0;
                        acc_next        = '0;
                        bytes_left_next = '0;
                    end
                    else
                    begin
                        acc_next       = acc_or;
                        digit_idx_next = digit_idx_reg + IDX_W'(1);
                        if (!data_byte[7])
                        begin
                            bytes_left_next = acc_or;
                            phase_next      = (acc_or == '0) ? PH_HEADER : PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    bytes_left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        phase_next     = PH_HEADER;
                        digit_idx_next = '0;
                        acc_next       = '0;
                    end
                end
                default:
                begin
                    // Expecting a header; the unused phase code lands here as well.
                    phase_next      = (data_byte == 8'd0) ? PH_HEADER : PH_LENGTH;
                    digit_idx_next  = '0;
                    acc_next        = '0;
                    bytes_left_next = '0;
                    if (data_byte != 8'd0)
                    begin
                        header_next = data_byte;
                    end
                end
            endcase
        end
    end

    // Result of the current byte.
    always_comb
    begin
        result.kind             = K_ERROR;
        result.byte_out         = data_byte;
        result.header_value     = 8'd0;
        result.remaining_length = '0;
        result.packet_end       = 1'b0;
        result.error_code       = E_ZERO_HEADER;
        if (no_data)
        begin
            result.byte_out   = 8'd0;
            result.error_code = E_MISSING;
        end
        else
        begin
            case (phase_reg)
                PH_LENGTH:
                begin
                    if (digit_idx_reg >= IDX_W'(MAX_LENGTH_BYTES))
                    begin
                        result.error_code = E_TOO_LONG;
                    end
                    else
                    begin
                        result.kind         = K_LENGTH;
                        result.header_value = header_reg;
                        if (!data_byte[7])
                        begin
                            result.remaining_length = acc_or;
                            result.packet_end       = (acc_or == '0);
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    result.kind             = K_PAYLOAD;
                    result.header_value     = header_reg;
                    result.remaining_length = acc_reg;
                    result.packet_end       = (left_dec == '0);
                end
                default:
                begin
                    if (data_byte != 8'd0)
                    begin
                        result.kind         = K_HEADER;
                        result.header_value = data_byte;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            digit_idx_reg  <= '0;
            acc_reg        <= '0;
            bytes_left_reg <= '0;
            header_reg     <= 8'd0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            digit_idx_reg  <= digit_idx_next;
            acc_reg        <= acc_next;
            bytes_left_reg <= bytes_left_next;
            header_reg     <= header_next;
        end
    end

    // Any error sends the framer back to header hunting with a clean length.
    a_error_resets: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.kind == K_ERROR |=> phase_reg == PH_HEADER && acc_reg == '0)
        else $error("framer did not return to header after an error");

    // The length digit index never runs past the length field limit.
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        digit_idx_reg <= IDX_W'(MAX_LENGTH_BYTES))
        else $error("length digit index out of range");

    // A packet end always closes the packet.
    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.packet_end |=> phase_reg == PH_HEADER)
        else $error("packet end did not return to header");

    // Errors never carry a packet end.
    a_err_no_end: assert property (@(posedge clk) disable iff (!rst_n)
        result.kind == K_ERROR |-> !result.packet_end)
        else $error("error result flagged as packet end");

endmodule
